[src/scaled_glyph_text_rasterizer_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the rasterizer checkers.
// ---------------------------------------------------------------------------
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_CORE_DEFINES_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define SGTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define SGTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/sgtr_pkg.sv]
// ---------------------------------------------------------------------------
// sgtr_pkg
// Types, constants, glyph table and control program of the text rasterizer.
// ---------------------------------------------------------------------------
package sgtr_pkg;

    localparam int CoordW  = 16;
    localparam int ColorW  = 16;
    localparam int ScaleW  = 8;
    localparam int ScreenW = 11;
    localparam int CodeW   = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;
    localparam int GlyphW  = 40;   // five column bytes, column 0 in the low byte

    localparam logic [CodeW-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CodeW-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CodeW-1:0] CHAR_FIRST   = 8'h21;
    localparam logic [CodeW-1:0] CHAR_LAST    = 8'h7E;

    localparam logic [CfgIdxW-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SCALE         = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_INK_COLOR     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd5;

    // Control program
    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE    = 3'd0;
    localparam step_t STEP_DECODE  = 3'd1;
    localparam step_t STEP_SCAN    = 3'd2;
    localparam step_t STEP_ADVANCE = 3'd3;
    localparam step_t STEP_NEWLINE = 3'd4;

    typedef enum logic [1:0] {
        COND_ALWAYS    = 2'd0,
        COND_WAIT_IN   = 2'd1,
        COND_NEWLINE   = 2'd2,
        COND_SCAN_BUSY = 2'd3
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  load;
        logic  scan;
        logic  advance;
        logic  newline;
        cond_t cond;
        step_t jump_to;
        step_t next_step;
    } ucode_t;

    // Jump when the condition holds, else fall through to next_step.
    localparam ucode_t UCODE [0:7] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_WAIT_IN,   STEP_IDLE,    STEP_DECODE},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEWLINE,   STEP_NEWLINE, STEP_SCAN},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_SCAN_BUSY, STEP_SCAN,    STEP_ADVANCE},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, COND_ALWAYS,    STEP_IDLE,    STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_ALWAYS,    STEP_IDLE,    STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_IDLE,    STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_IDLE,    STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_IDLE,    STEP_IDLE}
    };

    // Glyph table, column 0 in the leftmost hex byte, bit 0 is the lowest row.
    typedef logic [0:4][7:0] glyph_row_t;

    localparam glyph_row_t GLYPH_ROM [0:93] = '{
        40'h00007D0000, 40'h0070007000, 40'h287F287F28, 40'h122A6B2A24, 40'h6264081323,
        40'h3649552205, 40'h0050600000, 40'h001C224100, 40'h0041221C00, 40'h14083E0814,
        40'h08083E0808, 40'h0005060000, 40'h0808080808, 40'h0006060000, 40'h0204081020,
        40'h3E4549513E, 40'h00217F0100, 40'h2142454931, 40'h4241516946, 40'h0C14247F04,
        40'h725151514E, 40'h1E29494906, 40'h4047485060, 40'h3649494936, 40'h3049494A3C,
        40'h0036360000, 40'h0035360000, 40'h0814224100, 40'h1414141414, 40'h4122140800,
        40'h2040454830, 40'h26494F413E, 40'h3F4444443F, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F48484840, 40'h3E4149492E, 40'h7F0808087F,
        40'h00417F4100, 40'h0201417E40, 40'h7F08142241, 40'h7F01010101, 40'h7F2018207F,
        40'h7F1008047F, 40'h3E4141413E, 40'h7F48484830, 40'h3E4145423D, 40'h7F484C4A31,
        40'h3149494946, 40'h40407F4040, 40'h7E0101017E, 40'h7C0201027C, 40'h7E010E017E,
        40'h6314081463, 40'h7008070870, 40'h4345495161, 40'h007F414100, 40'h2010080402,
        40'h0041417F00, 40'h1020402010, 40'h0101010101, 40'h0040201000, 40'h021515150F,
        40'h7F0911110E, 40'h0E11111102, 40'h0E1111097F, 40'h0E1515150C, 40'h083F484020,
        40'h182525253E, 40'h7F0810100F, 40'h00115F0100, 40'h0201115E00, 40'h7F040A1100,
        40'h00417F0100, 40'h1F100C100F, 40'h1F0810100F, 40'h0E1111110E, 40'h1F14141408,
        40'h0814140C1F, 40'h1F08101008, 40'h0915151502, 40'h107E110102, 40'h1E0101021F,
        40'h1C0201021C, 40'h1E0106011E, 40'h110A040A11, 40'h180505051E, 40'h1113151911,
        40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0810100810
    };

    // Column bytes of one character, column 0 in the low byte.
    function automatic logic [GlyphW-1:0] glyph_bits(input logic [CodeW-1:0] code);
        logic [CodeW-1:0] idx;
        glyph_row_t       row;
        idx = code - CHAR_FIRST;
        row = GLYPH_ROM[idx[6:0]];
        if (code == CHAR_SPACE) begin
            glyph_bits = '0;
        end else if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
            glyph_bits = {row[4], row[3], row[2], row[1], row[0]};
        end else begin
            glyph_bits = '1;
        end
    endfunction

endpackage

[src/scaled_glyph_text_rasterizer_core.sv]
// ---------------------------------------------------------------------------
// scaled_glyph_text_rasterizer_core
// Turns a character stream into scaled 5x8 dot rectangles for a fill engine.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one character per transfer (s_char_code, s_first_of_string).
//     first_of_string puts the pen back to origin_x / origin_y first.
//   m_* channel: one dot rectangle per transfer; m_last_rect marks the last
//     rectangle of a character. Newline and space produce no rectangle.
//   cfg_*: plain register write port, one write per cycle, no read-back.
//     Write only while the block is idle.
// Timing:
//   A small control program steps a datapath: accept, decode, then for a
//   newline a line step, else a scan of each glyph bit position visited (at
//   most 40) until the glyph is found empty, then a pen update. s_ready
//   stays low from a character transfer until the program is back at idle,
//   so no new character is taken before the last one is finished. The
//   character code is registered, the decode step loads its glyph bits,
//   and the scan registers each set bit, lowest row of column 0 first, as
//   a rectangle in the output register. The bit scan, one bit a cycle,
//   sets the rate; a stalled receiver holds the scan on any cycle that
//   would emit a rectangle while the output register is still full.
// Reset:
//   aresetn (synchronous, active low) returns registers to their defaults,
//   clears the pen and baseline, and empties the output register.
// ---------------------------------------------------------------------------
module scaled_glyph_text_rasterizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [sgtr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sgtr_pkg::CfgDatW-1:0]  cfg_wdata,
    // character input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sgtr_pkg::CodeW-1:0]    s_char_code,
    input  logic                          s_first_of_string,
    // rectangle output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sgtr_pkg::CoordW-1:0]   m_rect_left,
    output logic [sgtr_pkg::CoordW-1:0]   m_rect_top,
    output logic [sgtr_pkg::CoordW-1:0]   m_rect_right,
    output logic [sgtr_pkg::CoordW-1:0]   m_rect_bottom,
    output logic [sgtr_pkg::ColorW-1:0]   m_fill_color,
    output logic                          m_visible,
    output logic                          m_last_rect
);

    // Configuration registers
    logic [sgtr_pkg::CoordW-1:0]  origin_x_reg;
    logic [sgtr_pkg::CoordW-1:0]  origin_y_reg;
    logic [sgtr_pkg::ScaleW-1:0]  scale_reg;
    logic [sgtr_pkg::ColorW-1:0]  ink_color_reg;
    logic [sgtr_pkg::ScreenW-1:0] screen_width_reg;
    logic [sgtr_pkg::ScreenW-1:0] screen_height_reg;

    // Sequencer and datapath
    sgtr_pkg::step_t              pc_reg, pc_next;
    sgtr_pkg::ucode_t             uword;
    logic [sgtr_pkg::CodeW-1:0]   code_reg, code_next;
    logic [sgtr_pkg::CoordW-1:0]  pen_reg, pen_next;
    logic [sgtr_pkg::CoordW-1:0]  base_reg, base_next;
    logic [sgtr_pkg::CoordW-1:0]  x_reg, x_next;      // left edge of current column
    logic [sgtr_pkg::CoordW-1:0]  yref_reg, yref_next; // bottom edge + 1 of current dot
    logic [sgtr_pkg::GlyphW-1:0]  glyph_reg, glyph_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [sgtr_pkg::CoordW-1:0]  left_reg, top_reg, right_reg, bottom_reg;
    logic [sgtr_pkg::ColorW-1:0]  color_reg;
    logic                         visible_reg, last_reg;

    logic                         in_xfer;
    logic                         out_free;
    logic                         glyph_busy;
    logic                         emit;
    logic                         scan_hold;
    logic                         cond_true;
    logic [sgtr_pkg::CoordW-1:0]  s16;
    logic [sgtr_pkg::CoordW-1:0]  rect_l, rect_r, rect_t, rect_b;
    logic                         rect_vis;

    assign uword      = sgtr_pkg::UCODE[pc_reg];
    assign s_ready    = uword.take_in;
    assign in_xfer    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign glyph_busy = (glyph_reg != '0);
    assign emit       = uword.scan && glyph_busy && glyph_reg[0] && out_free;
    // Hold the scan while a dot is due and the output register is still full.
    assign scan_hold  = uword.scan && glyph_busy && glyph_reg[0] && !out_free;
    assign s16        = {{(sgtr_pkg::CoordW-sgtr_pkg::ScaleW){1'b0}}, scale_reg};

    // Rectangle of the current dot; all sums wrap at 16 bits.
    assign rect_l   = x_reg;
    assign rect_r   = x_reg + s16 - 16'd1;
    assign rect_t   = yref_reg - s16;
    assign rect_b   = yref_reg - 16'd1;
    assign rect_vis = (rect_l <= rect_r) && (rect_t <= rect_b)
                   && (rect_r < {{(sgtr_pkg::CoordW-sgtr_pkg::ScreenW){1'b0}}, screen_width_reg})
                   && (rect_b < {{(sgtr_pkg::CoordW-sgtr_pkg::ScreenW){1'b0}}, screen_height_reg});

    // Branch condition of the current control word
    always_comb begin
        case (uword.cond)
            sgtr_pkg::COND_ALWAYS:    cond_true = 1'b1;
            sgtr_pkg::COND_WAIT_IN:   cond_true = !in_xfer;
            sgtr_pkg::COND_NEWLINE:   cond_true = (code_reg == sgtr_pkg::CHAR_NEWLINE);
            sgtr_pkg::COND_SCAN_BUSY: cond_true = glyph_busy;
            default:                  cond_true = 1'b1;
        endcase
        pc_next = cond_true ? uword.jump_to : uword.next_step;
    end

    // Datapath next values
    always_comb begin
        code_next  = code_reg;
        pen_next   = pen_reg;
        base_next  = base_reg;
        x_next     = x_reg;
        yref_next  = yref_reg;
        glyph_next = glyph_reg;

        // take the character; a new string restarts the pen
        if (in_xfer) begin
            code_next = s_char_code;
            if (s_first_of_string) begin
                pen_next  = '0;
                base_next = origin_y_reg;
            end
        end

        // latch column origin and glyph bits
        if (uword.load) begin
            x_next     = origin_x_reg + pen_reg;
            yref_next  = base_reg;
            glyph_next = sgtr_pkg::glyph_bits(code_reg);
        end

        // one bit position a cycle unless held; drop a column with upper bits clear
        if (uword.scan && glyph_busy && !scan_hold) begin
            if (glyph_reg[7:1] == '0) begin
                glyph_next = {8'h00, glyph_reg[sgtr_pkg::GlyphW-1:8]};
                x_next     = x_reg + s16;
                yref_next  = base_reg;
            end else begin
                glyph_next = {glyph_reg[sgtr_pkg::GlyphW-1:8], 1'b0, glyph_reg[7:1]};
                yref_next  = yref_reg - s16;
            end
        end

        // advance pen by six dots
        if (uword.advance) begin
            pen_next = pen_reg + {s16[sgtr_pkg::CoordW-3:0], 2'b00}
                               + {s16[sgtr_pkg::CoordW-2:0], 1'b0};
        end

        // newline: back to column zero, down eight dots
        if (uword.newline) begin
            pen_next  = '0;
            base_next = base_reg + {s16[sgtr_pkg::CoordW-4:0], 3'b000};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg            <= sgtr_pkg::STEP_IDLE;
            pen_reg           <= '0;
            base_reg          <= '0;
            m_valid_reg       <= 1'b0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            scale_reg         <= 8'd1;
            ink_color_reg     <= '0;
            screen_width_reg  <= 11'd240;
            screen_height_reg <= 11'd320;
        end else begin
            pc_reg      <= pc_next;
            pen_reg     <= pen_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sgtr_pkg::REG_ORIGIN_X:      origin_x_reg      <= cfg_wdata;
                    sgtr_pkg::REG_ORIGIN_Y:      origin_y_reg      <= cfg_wdata;
                    sgtr_pkg::REG_SCALE:         scale_reg         <= cfg_wdata[sgtr_pkg::ScaleW-1:0];
                    sgtr_pkg::REG_INK_COLOR:     ink_color_reg     <= cfg_wdata;
                    sgtr_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[sgtr_pkg::ScreenW-1:0];
                    sgtr_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[sgtr_pkg::ScreenW-1:0];
                    default: begin
                        // unused index: drop the write
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        x_reg     <= x_next;
        yref_reg  <= yref_next;
        glyph_reg <= glyph_next;
        if (emit) begin
            left_reg    <= rect_l;
            top_reg     <= rect_t;
            right_reg   <= rect_r;
            bottom_reg  <= rect_b;
            color_reg   <= ink_color_reg;
            visible_reg <= rect_vis;
            // final dot when no set bit remains above this one
            last_reg    <= (glyph_reg[sgtr_pkg::GlyphW-1:1] == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rect_left   = left_reg;
    assign m_rect_top    = top_reg;
    assign m_rect_right  = right_reg;
    assign m_rect_bottom = bottom_reg;
    assign m_fill_color  = color_reg;
    assign m_visible     = visible_reg;
    assign m_last_rect   = last_reg;

endmodule

[src/sgtr_checker.sv]
// ---------------------------------------------------------------------------
// sgtr_checker
// Port-level checks on the text rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "scaled_glyph_text_rasterizer_core_defines.svh"

module sgtr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sgtr_pkg::CoordW-1:0]   m_rect_left,
    input logic [sgtr_pkg::CoordW-1:0]   m_rect_top,
    input logic [sgtr_pkg::CoordW-1:0]   m_rect_right,
    input logic [sgtr_pkg::CoordW-1:0]   m_rect_bottom,
    input logic                          m_visible,
    input logic                          m_last_rect
);

    // a character transfer starts work; no second character is taken at once
    `SGTR_ASSERT_NEXT(a_one_char_at_a_time, s_valid && s_ready, !s_ready,
        "second char taken back to back")

    // a stalled rectangle stays valid and holds its left and bottom edges
    `SGTR_ASSERT_NEXT(a_rect_hold, m_valid && !m_ready,
        m_valid && $stable(m_rect_left) && $stable(m_rect_bottom),
        "stalled rectangle changed")

    // a visible rectangle is well ordered
    `SGTR_ASSERT_NOW(a_visible_ordered, m_valid && m_visible,
        (m_rect_left <= m_rect_right) && (m_rect_top <= m_rect_bottom),
        "visible rectangle out of order")

    // a character transfer with no rectangle pending brings none out in the next cycle
    `SGTR_ASSERT_NEXT(a_no_rect_after_char, s_valid && s_ready && !m_valid, !m_valid,
        "rectangle right after a character transfer")

    // a valid rectangle always carries a known last flag
    `SGTR_ASSERT_NOW(a_last_flag_known, m_valid, !$isunknown(m_last_rect),
        "last flag unknown on a valid rectangle")

endmodule

bind scaled_glyph_text_rasterizer_core sgtr_checker u_sgtr_checker (.*);

[verif/sgtr_rect_checker.sv]
// ---------------------------------------------------------------------------
// sgtr_rect_checker
// Watches the character and rectangle channels of the text rasterizer,
// predicts every dot rectangle from a mirror of the registers and the pen,
// and compares each rectangle transfer field by field in arrival order.
// ---------------------------------------------------------------------------
module sgtr_rect_checker
    import sgtr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDatW-1:0]   cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [CodeW-1:0]     s_char_code,
    input  logic                 s_first_of_string,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CoordW-1:0]    m_rect_left,
    input  logic [CoordW-1:0]    m_rect_top,
    input  logic [CoordW-1:0]    m_rect_right,
    input  logic [CoordW-1:0]    m_rect_bottom,
    input  logic [ColorW-1:0]    m_fill_color,
    input  logic                 m_visible,
    input  logic                 m_last_rect,
    output int unsigned          pending_rects,
    output int unsigned          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Five column bytes per printable code, column 0 in the top byte.
    localparam logic [GlyphW-1:0] FONT_COLS [0:93] = '{
        40'h00007D0000, 40'h0070007000, 40'h287F287F28, 40'h122A6B2A24, 40'h6264081323,
        40'h3649552205, 40'h0050600000, 40'h001C224100, 40'h0041221C00, 40'h14083E0814,
        40'h08083E0808, 40'h0005060000, 40'h0808080808, 40'h0006060000, 40'h0204081020,
        40'h3E4549513E, 40'h00217F0100, 40'h2142454931, 40'h4241516946, 40'h0C14247F04,
        40'h725151514E, 40'h1E29494906, 40'h4047485060, 40'h3649494936, 40'h3049494A3C,
        40'h0036360000, 40'h0035360000, 40'h0814224100, 40'h1414141414, 40'h4122140800,
        40'h2040454830, 40'h26494F413E, 40'h3F4444443F, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F48484840, 40'h3E4149492E, 40'h7F0808087F,
        40'h00417F4100, 40'h0201417E40, 40'h7F08142241, 40'h7F01010101, 40'h7F2018207F,
        40'h7F1008047F, 40'h3E4141413E, 40'h7F48484830, 40'h3E4145423D, 40'h7F484C4A31,
        40'h3149494946, 40'h40407F4040, 40'h7E0101017E, 40'h7C0201027C, 40'h7E010E017E,
        40'h6314081463, 40'h7008070870, 40'h4345495161, 40'h007F414100, 40'h2010080402,
        40'h0041417F00, 40'h1020402010, 40'h0101010101, 40'h0040201000, 40'h021515150F,
        40'h7F0911110E, 40'h0E11111102, 40'h0E1111097F, 40'h0E1515150C, 40'h083F484020,
        40'h182525253E, 40'h7F0810100F, 40'h00115F0100, 40'h0201115E00, 40'h7F040A1100,
        40'h00417F0100, 40'h1F100C100F, 40'h1F0810100F, 40'h0E1111110E, 40'h1F14141408,
        40'h0814140C1F, 40'h1F08101008, 40'h0915151502, 40'h107E110102, 40'h1E0101021F,
        40'h1C0201021C, 40'h1E0106011E, 40'h110A040A11, 40'h180505051E, 40'h1113151911,
        40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0810100810
    };

    typedef struct {
        logic [CoordW-1:0] rect_left;
        logic [CoordW-1:0] rect_top;
        logic [CoordW-1:0] rect_right;
        logic [CoordW-1:0] rect_bottom;
        logic [ColorW-1:0] fill_color;
        logic              visible;
        logic              last_rect;
    } dot_rect_t;

    dot_rect_t           expected_rects [$];
    int unsigned         err_total = 0;

    // register mirror and pen
    logic [CoordW-1:0]   org_x;
    logic [CoordW-1:0]   org_y;
    logic [ScaleW-1:0]   dot_scale;
    logic [ColorW-1:0]   ink;
    logic [ScreenW-1:0]  scr_width;
    logic [ScreenW-1:0]  scr_height;
    logic [CoordW-1:0]   pen_col;
    logic [CoordW-1:0]   baseline;

    task automatic report(input string msg);
        err_total++;
        $display("[%0t] rect check: %s", $time, msg);
    endtask

    // Append the rectangles of one character and move the pen.
    task automatic rasterize_char(input logic [CodeW-1:0] code, input logic first);
        logic [CoordW-1:0] s16;
        logic [CoordW-1:0] x0;
        logic [CoordW-1:0] rowoff;
        logic [GlyphW-1:0] glyph;
        logic [7:0]        bits;
        dot_rect_t         rect;
        int unsigned       emitted;
        int                col;
        s16     = {8'd0, dot_scale};
        emitted = 0;
        if (first) begin
            pen_col  = '0;
            baseline = org_y;
        end
        if (code == CHAR_NEWLINE) begin
            pen_col  = '0;
            baseline = baseline + (s16 << 3);
        end else begin
            x0 = org_x + pen_col;
            for (col = 0; col < 5; col++) begin
                if (code == CHAR_SPACE) begin
                    bits = 8'h00;
                end else if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
                    glyph = FONT_COLS[code - CHAR_FIRST];
                    bits  = 8'(glyph >> (8 * (4 - col)));
                end else begin
                    bits = 8'hFF;
                end
                rowoff = '0;
                // scan upward, stop once no set bits remain
                while (bits != 8'h00) begin
                    if (bits[0]) begin
                        rect.rect_left   = x0 + CoordW'(col) * s16;
                        rect.rect_right  = rect.rect_left + s16 - 16'd1;
                        rect.rect_top    = baseline - rowoff - s16;
                        rect.rect_bottom = baseline - rowoff - 16'd1;
                        rect.fill_color  = ink;
                        rect.visible     = (rect.rect_left <= rect.rect_right)
                                        && (rect.rect_top <= rect.rect_bottom)
                                        && (rect.rect_right < {5'd0, scr_width})
                                        && (rect.rect_bottom < {5'd0, scr_height});
                        rect.last_rect   = 1'b0;
                        expected_rects.push_back(rect);
                        emitted++;
                    end
                    bits   = bits >> 1;
                    rowoff = rowoff + s16;
                end
            end
            if (emitted > 0) begin
                expected_rects[expected_rects.size() - 1].last_rect = 1'b1;
            end
            pen_col = pen_col + 16'd6 * s16;
        end
    endtask

    always @(posedge aclk) begin
        dot_rect_t want;
        if (!aresetn) begin
            org_x      = '0;
            org_y      = '0;
            dot_scale  = 8'd1;
            ink        = '0;
            scr_width  = 11'd240;
            scr_height = 11'd320;
            pen_col    = '0;
            baseline   = '0;
            expected_rects.delete();
        end else begin
            // retire the oldest expectation before adding new ones
            if (m_valid && m_ready) begin
                if (expected_rects.size() == 0) begin
                    report($sformatf("unexpected rectangle left=%0h top=%0h",
                                     m_rect_left, m_rect_top));
                end else begin
                    want = expected_rects.pop_front();
                    if (m_rect_left !== want.rect_left)
                        report($sformatf("rect_left exp %0h got %0h",
                                         want.rect_left, m_rect_left));
                    if (m_rect_top !== want.rect_top)
                        report($sformatf("rect_top exp %0h got %0h",
                                         want.rect_top, m_rect_top));
                    if (m_rect_right !== want.rect_right)
                        report($sformatf("rect_right exp %0h got %0h",
                                         want.rect_right, m_rect_right));
                    if (m_rect_bottom !== want.rect_bottom)
                        report($sformatf("rect_bottom exp %0h got %0h",
                                         want.rect_bottom, m_rect_bottom));
                    if (m_fill_color !== want.fill_color)
                        report($sformatf("fill_color exp %0h got %0h",
                                         want.fill_color, m_fill_color));
                    if (m_visible !== want.visible)
                        report($sformatf("visible exp %0b got %0b",
                                         want.visible, m_visible));
                    if (m_last_rect !== want.last_rect)
                        report($sformatf("last_rect exp %0b got %0b",
                                         want.last_rect, m_last_rect));
                end
            end
            if (s_valid && s_ready) begin
                rasterize_char(s_char_code, s_first_of_string);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ORIGIN_X:      org_x      = cfg_wdata;
                    REG_ORIGIN_Y:      org_y      = cfg_wdata;
                    REG_SCALE:         dot_scale  = cfg_wdata[ScaleW-1:0];
                    REG_INK_COLOR:     ink        = cfg_wdata;
                    REG_SCREEN_WIDTH:  scr_width  = cfg_wdata[ScreenW-1:0];
                    REG_SCREEN_HEIGHT: scr_height = cfg_wdata[ScreenW-1:0];
                    default: ;
                endcase
            end
        end
        pending_rects <= expected_rects.size();
        fail_count    <= err_total;
    end

endmodule

[verif/tb_scaled_glyph_text_rasterizer_core.sv]
// ---------------------------------------------------------------------------
// tb_scaled_glyph_text_rasterizer_core
// Drives character strings into the rasterizer under several register
// settings, with bursty input and a stalling receiver; the rectangle checker
// beside the block predicts and compares, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_scaled_glyph_text_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sgtr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // settle time: long enough for the longest character to run from transfer to next ready
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned RANDOM_ITEMS   = 110;
    localparam int unsigned NUM_PHASES     = 6;
    localparam int unsigned DIRECTED_ITEMS = 22;

    // indexes past the register list; writes there must be ignored
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CoordW-1:0]  org_x;
        logic [CoordW-1:0]  org_y;
        logic [ScaleW-1:0]  dot_scale;
        logic [ColorW-1:0]  ink;
        logic [ScreenW-1:0] scr_width;
        logic [ScreenW-1:0] scr_height;
    } reg_set_t;

    // Directed text at reset defaults: both ends of the printable range,
    // space, newline, code zero, high codes, DEL and other controls that
    // fall back to the solid block.
    localparam logic [CodeW-1:0] DIR_CODES [0:DIRECTED_ITEMS-1] = '{
        "A", CHAR_FIRST, CHAR_LAST, CHAR_SPACE, CHAR_NEWLINE, "H", 8'h00, 8'hFF,
        8'h80, 8'h7F, 8'h1F, CHAR_NEWLINE, "g", 8'h09, 8'h0B, CHAR_NEWLINE,
        "8", "@", CHAR_SPACE, "|", 8'hAA, 8'h55
    };
    localparam logic [DIRECTED_ITEMS-1:0] DIR_FIRST = 22'b0000_0100_0000_1000_0000_01;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDatW-1:0] cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [CodeW-1:0]   s_char_code;
    logic               s_first_of_string;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CoordW-1:0]  m_rect_left;
    logic [CoordW-1:0]  m_rect_top;
    logic [CoordW-1:0]  m_rect_right;
    logic [CoordW-1:0]  m_rect_bottom;
    logic [ColorW-1:0]  m_fill_color;
    logic               m_visible;
    logic               m_last_rect;

    int unsigned        pending_rects;
    int unsigned        fail_count;
    int unsigned        burst_left;
    int unsigned        idle_cycles = 0;

    // receiver stall state
    logic [6:0]         rx_tick = '0;
    logic [1:0]         rx_mode = '0;
    int unsigned        rx_hold = 0;

    scaled_glyph_text_rasterizer_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_code       (s_char_code),
        .s_first_of_string (s_first_of_string),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rect_left       (m_rect_left),
        .m_rect_top        (m_rect_top),
        .m_rect_right      (m_rect_right),
        .m_rect_bottom     (m_rect_bottom),
        .m_fill_color      (m_fill_color),
        .m_visible         (m_visible),
        .m_last_rect       (m_last_rect)
    );

    sgtr_rect_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_code       (s_char_code),
        .s_first_of_string (s_first_of_string),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rect_left       (m_rect_left),
        .m_rect_top        (m_rect_top),
        .m_rect_right      (m_rect_right),
        .m_rect_bottom     (m_rect_bottom),
        .m_fill_color      (m_fill_color),
        .m_visible         (m_visible),
        .m_last_rect       (m_last_rect),
        .pending_rects     (pending_rects),
        .fail_count        (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: pick a new stall style each time the 7-bit tick counter wraps.
    // Always ready, random drops, a fixed duty pattern, or random long holds.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 7'd1;
        if (rx_tick == 7'd0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= (rx_tick[2:0] < 3'd5);
            default: begin
                if (rx_hold != 0) begin
                    m_ready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) begin
                        rx_hold <= $urandom_range(1, 20);
                    end
                end
            end
        endcase
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one character and hold it until the transfer. Keep valid high
    // across a burst; drop it when the burst runs out and idle before the
    // next one.
    task automatic send_char(input logic [CodeW-1:0] code, input logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
        end
        s_valid           <= 1'b1;
        s_char_code       <= code;
        s_first_of_string <= first;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
        end
    endtask

    // Drop valid, wait for every expected rectangle, then let a trailing
    // space or newline finish inside the block.
    task automatic drain_and_settle();
        if (burst_left != 0) begin
            s_valid    <= 1'b0;
            burst_left = 0;
        end
        do @(posedge aclk); while (pending_rects != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all six registers plus one spare index, one write per cycle.
    task automatic program_regs(input reg_set_t rs, input logic [CfgIdxW-1:0] spare);
        logic [CfgIdxW-1:0] idx [0:6];
        logic [CfgDatW-1:0] dat [0:6];
        int                 k;
        idx = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_SCALE, REG_INK_COLOR,
                REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, spare};
        dat = '{rs.org_x, rs.org_y, {8'd0, rs.dot_scale}, rs.ink,
                {5'd0, rs.scr_width}, {5'd0, rs.scr_height}, 16'($urandom)};
        for (k = 0; k < 7; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_wdata <= dat[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        reg_set_t    presets [0:NUM_PHASES-1];
        reg_set_t    rs;
        int unsigned phase;
        int unsigned n;
        int unsigned sel;
        logic [CodeW-1:0] code;
        logic        first;

        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_char_code       = '0;
        s_first_of_string = 1'b0;
        burst_left        = 0;

        // ordinary text, all-ones origin/scale/ink, zero scale and screen,
        // x wrap with 11-bit max screen, a random mid setting, 1x1 screen
        presets[0] = '{16'd10, 16'd200, 8'd1, 16'hF800, 11'd240, 11'd320};
        presets[1] = '{16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 11'd1024, 11'd1024};
        presets[2] = '{16'd0, 16'd0, 8'd0, 16'd0, 11'd0, 11'd0};
        presets[3] = '{16'hFFF0, 16'd40, 8'd2, 16'h07E0, 11'h7FF, 11'h7FF};
        presets[4] = '{16'($urandom_range(0, 300)), 16'($urandom_range(8, 400)),
                       8'($urandom_range(1, 4)), 16'($urandom),
                       11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024))};
        presets[5] = '{16'd0, 16'd7, 8'd1, 16'h001F, 11'd1, 11'd1};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed text at reset defaults
        for (n = 0; n < DIRECTED_ITEMS; n++) begin
            send_char(DIR_CODES[n], DIR_FIRST[n]);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_and_settle();
            rs = presets[phase];
            program_regs(rs, phase[0] ? REG_SPARE_HI : REG_SPARE_LO);
            // mostly printable strings, some spaces and newlines, the rest
            // any byte; open each phase with a fresh string
            for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                sel   = $urandom_range(0, 99);
                first = (n == 0) || ($urandom_range(0, 15) == 0);
                if (sel < 68) begin
                    code = CodeW'($urandom_range(CHAR_FIRST, CHAR_LAST));
                end else if (sel < 78) begin
                    code = CHAR_SPACE;
                end else if (sel < 86) begin
                    code = CHAR_NEWLINE;
                end else begin
                    code = CodeW'($urandom_range(0, 255));
                end
                send_char(code, first);
            end
        end

        drain_and_settle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
